// ----- rtl/lbf_pkg.sv -----
`timescale 1ns / 1ps

package lbf_pkg;

  // Field widths
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned COUNT_W    = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAR_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_INTERVAL = 2'd2;

  // Register reset values
  localparam logic [7:0] FADE_SCALE_RST   = 8'd230;
  localparam logic [7:0] DIM_INTERVAL_RST = 8'd20;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_END    = 2'd1,
    MODE_CENTER = 2'd2,
    MODE_ENDS   = 2'd3
  } bar_mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // One LED on its way from the read stage to the output stage
  typedef struct packed {
    logic             vld;
    logic             paint;
    logic             last;
    logic [IDX_W-1:0] idx;
  } px_t;

  // Scale each channel by (scale+1)/256
  function automatic logic [RGB_W-1:0] dim_rgb(input logic [RGB_W-1:0] rgb,
                                               input logic [7:0]       scale);
    logic [8:0]  s;
    logic [16:0] p_r;
    logic [16:0] p_g;
    logic [16:0] p_b;
    s   = {1'b0, scale} + 9'd1;
    p_r = 17'(rgb[23:16]) * 17'(s);
    p_g = 17'(rgb[15:8])  * 17'(s);
    p_b = 17'(rgb[7:0])   * 17'(s);
    return {p_r[15:8], p_g[15:8], p_b[15:8]};
  endfunction

endpackage

// ----- rtl/lbf_store.sv -----
`timescale 1ns / 1ps

module lbf_store #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [$clog2(LED_COUNT)-1:0]     rd_addr_i,
  output logic [lbf_pkg::RGB_W-1:0]        rd_data_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(LED_COUNT)-1:0]     wr_addr_i,
  input  logic [lbf_pkg::RGB_W-1:0]        wr_data_i
);
  import lbf_pkg::*;

  logic [RGB_W-1:0]     mem_q [LED_COUNT];
  logic [RGB_W-1:0]     rdata_q;
  logic [LED_COUNT-1:0] vld_q;
  logic                 rvld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Track written entries; unwritten ones read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/lbf_shade.sv -----
`timescale 1ns / 1ps

module lbf_shade #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lbf_pkg::px_t                     px_i,
  input  logic [lbf_pkg::RGB_W-1:0]        old_rgb_i,
  input  logic [lbf_pkg::RGB_W-1:0]        color_i,
  input  logic                             dim_i,
  input  logic [7:0]                       fade_scale_i,
  output logic                             adv_o,
  output logic                             wr_en_o,
  output logic [$clog2(LED_COUNT)-1:0]     wr_addr_o,
  output logic [lbf_pkg::RGB_W-1:0]        wr_data_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lbf_pkg::IDX_W-1:0]        led_index_o,
  output logic [lbf_pkg::RGB_W-1:0]        led_rgb_o,
  output logic                             last_o
);
  import lbf_pkg::*;

  logic             out_vld_q;
  logic [IDX_W-1:0] idx_q;
  logic [RGB_W-1:0] rgb_q;
  logic             last_q;
  logic [RGB_W-1:0] faded;
  logic [RGB_W-1:0] new_rgb;

  // Move on when the output word is empty or being taken
  assign adv_o = !out_vld_q || !out_stall_i;

  // Dim, then paint over
  always_comb begin
    faded   = dim_i ? dim_rgb(old_rgb_i, fade_scale_i) : old_rgb_i;
    new_rgb = px_i.paint ? color_i : faded;
  end

  // Write back the new LED value
  assign wr_en_o   = px_i.vld && adv_o;
  assign wr_addr_o = px_i.idx[$clog2(LED_COUNT)-1:0];
  assign wr_data_o = new_rgb;

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= px_i.vld;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (adv_o && px_i.vld) begin
      idx_q  <= px_i.idx;
      rgb_q  <= new_rgb;
      last_q <= px_i.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign led_index_o = idx_q;
  assign led_rgb_o   = rgb_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/led_bar_fade_renderer.sv -----
`timescale 1ns / 1ps

// LED bar fade renderer.
// Input channel (in_valid_i / in_stall_o) takes one word per frame tick: a
// level and a bar color. Output channel (out_valid_o / out_stall_i) gives
// LED_COUNT words per frame, one per LED in index order, last_o set on the
// final LED. Registers (bar mode, fade scale, dim interval) are written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Each frame is one sweep over the frame store: each entry in turn is read,
// dimmed if the frame counter passed the interval, painted if it lies in
// the bar, written back and sent out. The input word is registered, each
// entry passes the store read register and the read stage into the output
// register, and the next input word is taken only once the read stage has
// emptied after the last LED. The sweep reads one store entry and writes
// one back per cycle while the output does not stall: one LED per cycle.
// Reset clears the frame counter, returns the registers to their defaults,
// and marks every store entry unwritten so it reads black; no clearing pass
// is needed. When the receiver stalls, the sweep holds with the current word
// in the output register and advances at the edge where that word is taken.
module led_bar_fade_renderer #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lbf_pkg::LEVEL_W-1:0]        level_i,
  input  logic [lbf_pkg::RGB_W-1:0]          color_rgb_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lbf_pkg::IDX_W-1:0]          led_index_o,
  output logic [lbf_pkg::RGB_W-1:0]          led_rgb_o,
  output logic                               last_o
);
  import lbf_pkg::*;

  localparam int unsigned AW = $clog2(LED_COUNT);
  localparam logic [LEN_W-1:0] NUM  = LEN_W'(LED_COUNT);
  localparam logic [LEN_W-1:0] HALF = LEN_W'(LED_COUNT / 2);
  localparam logic [AW-1:0]    LAST_IDX = AW'(LED_COUNT - 1);

  state_e              state_q, state_d;
  bar_mode_e           mode_q;
  logic [7:0]          fade_q;
  logic [7:0]          intv_q;
  logic [COUNT_W-1:0]  fc_q;
  logic [COUNT_W-1:0]  fc_inc;
  logic                dim_now;
  logic [AW-1:0]       cnt_q;
  logic [RGB_W-1:0]    color_q;
  logic [LEN_W-1:0]    len_q;
  logic                dim_q;
  logic [14:0]         prod;
  logic [14:0]         quot;
  logic                in_acc;
  logic                issue;
  logic                adv;
  logic                paint;
  logic [LEN_W-1:0]    pos;
  logic [LEN_W-1:0]    rpos;
  logic [LEN_W-1:0]    hlen;
  px_t                 px_q;
  logic [RGB_W-1:0]    old_rgb;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [RGB_W-1:0]    wr_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      fade_q <= FADE_SCALE_RST;
      intv_q <= DIM_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BAR_MODE:     mode_q <= bar_mode_e'(cfg_data_i[1:0]);
        REG_FADE_SCALE:   fade_q <= cfg_data_i;
        REG_DIM_INTERVAL: intv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // Frame counter and dim decision
  assign fc_inc  = fc_q + COUNT_W'(1);
  assign dim_now = fc_inc > {1'b0, intv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
    end else if (in_acc) begin
      fc_q <= dim_now ? '0 : fc_inc;
    end
  end

  // Bar length: floor(N*level/255) by reciprocal with correction
  always_comb begin
    prod = 15'(NUM) * 15'(level_i);
    quot = (prod + 15'd1 + (prod >> 8)) >> 8;
  end

  // Hold frame parameters for the sweep
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      color_q <= color_rgb_i;
      len_q   <= quot[LEN_W-1:0];
      dim_q   <= dim_now;
    end
  end

  // Sweep state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (issue && cnt_q == LAST_IDX) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and read issue
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = px_q.vld;
      ST_RUN:  issue      = adv;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + AW'(1);
      end
    end
  end

  // Decide whether the LED being read lies in the bar
  always_comb begin
    pos   = LEN_W'(cnt_q);
    rpos  = NUM - LEN_W'(1) - pos;
    hlen  = len_q >> 1;
    paint = 1'b0;
    case (mode_q)
      MODE_START:  paint = pos < len_q;
      MODE_END:    paint = rpos < len_q;
      MODE_CENTER: paint = (pos < HALF) ? ((HALF - LEN_W'(1) - pos) < hlen)
                                        : ((pos - HALF) < hlen);
      MODE_ENDS:   paint = (pos < hlen) || (rpos < hlen);
      default:     paint = 1'b0;
    endcase
  end

  // Read stage: advance with the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
    end else if (adv) begin
      px_q.vld   <= issue;
      px_q.paint <= paint;
      px_q.last  <= cnt_q == LAST_IDX;
      px_q.idx   <= IDX_W'(cnt_q);
    end
  end

  lbf_store #(
    .LED_COUNT (LED_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (cnt_q),
    .rd_data_o (old_rgb),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lbf_shade #(
    .LED_COUNT (LED_COUNT)
  ) u_shade (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .px_i         (px_q),
    .old_rgb_i    (old_rgb),
    .color_i      (color_q),
    .dim_i        (dim_q),
    .fade_scale_i (fade_q),
    .adv_o        (adv),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_index_o  (led_index_o),
    .led_rgb_o    (led_rgb_o),
    .last_o       (last_o)
  );

endmodule
